// ===== hdl/sqe_pkg.sv =====
// ----------------------------------------------------------------------------
// sqe_pkg
// Types and constants shared by the shadow quad extruder modules.
// ----------------------------------------------------------------------------
package sqe_pkg;

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned FRAC_W    = 4;
  localparam int unsigned OUT_W     = 20;
  localparam int unsigned STRETCH_W = 14;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 32;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_ON = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRETCH  = 8'd3;

  localparam logic [STRETCH_W-1:0] STRETCH_RST = 14'd1024;

  typedef struct packed {
    logic signed [COORD_W-1:0] vert_x;
    logic signed [COORD_W-1:0] vert_y;
    logic                      closes_polygon;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] near_a_x;
    logic signed [OUT_W-1:0] near_a_y;
    logic signed [OUT_W-1:0] near_b_x;
    logic signed [OUT_W-1:0] near_b_y;
    logic signed [OUT_W-1:0] far_b_x;
    logic signed [OUT_W-1:0] far_b_y;
    logic signed [OUT_W-1:0] far_a_x;
    logic signed [OUT_W-1:0] far_a_y;
    logic                    last_quad;
  } out_item_t;

  // one edge to extrude, front to back
  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic                      last;
  } quad_cmd_t;

  typedef struct packed {
    logic                        light_on;
    logic signed [COORD_W-1:0]   light_x;
    logic signed [COORD_W-1:0]   light_y;
    logic [STRETCH_W-1:0]        stretch;
  } cfg_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [OUT_W:0] v);
    logic signed [OUT_W:0] hi;
    logic signed [OUT_W:0] lo;
    hi = {2'b00, {(OUT_W-1){1'b1}}};
    lo = {2'b11, {(OUT_W-1){1'b0}}};
    if (v > hi) begin
      sat_out = hi[OUT_W-1:0];
    end else if (v < lo) begin
      sat_out = lo[OUT_W-1:0];
    end else begin
      sat_out = v[OUT_W-1:0];
    end
  endfunction

endpackage

// ===== hdl/sqe_front.sv =====
// ----------------------------------------------------------------------------
// sqe_front
// Accepts vertices, tracks the open polygon and issues edge commands.
// ----------------------------------------------------------------------------
module sqe_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               light_on_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sqe_pkg::in_item_t  in_item_i,
  output logic               push_o,
  output sqe_pkg::quad_cmd_t cmd_o,
  input  logic               full_i
);
  import sqe_pkg::*;

  logic                      open_q, open_d;
  logic                      phase_q, phase_d;
  logic signed [COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic                      accept;

  always_comb begin
    push_o     = 1'b0;
    in_ready_o = 1'b0;
    phase_d    = phase_q;
    cmd_o      = '{ax: in_item_i.vert_x, ay: in_item_i.vert_y,
                   bx: in_item_i.vert_x, by: in_item_i.vert_y, last: 1'b1};
    if (!light_on_i) begin
      in_ready_o = 1'b1;
    end else if (!open_q) begin
      in_ready_o = !(in_item_i.closes_polygon && full_i);
      push_o     = in_valid_i && in_item_i.closes_polygon && !full_i;
    end else if (!phase_q) begin
      cmd_o.ax   = prev_x_q;
      cmd_o.ay   = prev_y_q;
      cmd_o.last = !in_item_i.closes_polygon;
      push_o     = in_valid_i && !full_i;
      in_ready_o = !full_i && !in_item_i.closes_polygon;
      if (in_valid_i && !full_i && in_item_i.closes_polygon) begin
        phase_d = 1'b1;
      end
    end else begin
      // closing edge back to the first vertex
      cmd_o.bx   = first_x_q;
      cmd_o.by   = first_y_q;
      push_o     = in_valid_i && !full_i;
      in_ready_o = !full_i;
      if (in_valid_i && !full_i) begin
        phase_d = 1'b0;
      end
    end
  end

  assign accept = in_valid_i && in_ready_o && light_on_i;

  always_comb begin
    open_d = open_q;
    if (accept) begin
      open_d = open_q ? !in_item_i.closes_polygon : !in_item_i.closes_polygon;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q    <= 1'b0;
      phase_q   <= 1'b0;
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
    end else begin
      open_q  <= open_d;
      phase_q <= phase_d;
      if (accept) begin
        prev_x_q <= in_item_i.vert_x;
        prev_y_q <= in_item_i.vert_y;
        if (!open_q) begin
          first_x_q <= in_item_i.vert_x;
          first_y_q <= in_item_i.vert_y;
        end
      end
    end
  end

endmodule

// ===== hdl/sqe_queue.sv =====
// ----------------------------------------------------------------------------
// sqe_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module sqe_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sqe_pkg::quad_cmd_t wdata_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output sqe_pkg::quad_cmd_t rdata_o
);
  import sqe_pkg::*;

  quad_cmd_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/sqe_extrude.sv =====
// ----------------------------------------------------------------------------
// sqe_extrude
// Extrudes both ends of an edge away from the light and drives the result.
// ----------------------------------------------------------------------------
module sqe_extrude (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sqe_pkg::cfg_t       cfg_i,
  input  logic                cmd_valid_i,
  input  sqe_pkg::quad_cmd_t  cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sqe_pkg::out_item_t  out_item_o
);
  import sqe_pkg::*;

  localparam int unsigned MAG_W  = COORD_W;
  localparam int unsigned S_W    = STRETCH_W + FRAC_W;
  localparam int unsigned PROD_W = S_W + MAG_W;
  localparam int unsigned RAD_W  = 50;
  localparam int unsigned R_W    = 25;
  localparam int unsigned NUM_W  = 46;
  localparam int unsigned Q_W    = 19;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIFF  = 4'd1;
  localparam logic [3:0] ST_SQX   = 4'd2;
  localparam logic [3:0] ST_SQY   = 4'd3;
  localparam logic [3:0] ST_SQRT  = 4'd4;
  localparam logic [3:0] ST_MUL   = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_STORE = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0]                state_q;
  quad_cmd_t                 cmd_q;
  logic                      sel_q, axis_q;
  logic signed [COORD_W-1:0] px_q, py_q;
  logic [MAG_W-1:0]          adx_q, ady_q;
  logic                      negx_q, negy_q;
  logic [PROD_W-1:0]         acc_q;
  logic [RAD_W-1:0]          rad_q, root_q, bit_q;
  logic [NUM_W-1:0]          rem_q, den_q;
  logic [Q_W-1:0]            quo_q;
  logic [4:0]                dcnt_q;
  logic signed [OUT_W-1:0]   offx_q;
  logic signed [OUT_W-1:0]   fax_q, fay_q, fbx_q, fby_q;
  logic                      out_valid_q;
  out_item_t                 out_q;

  logic signed [COORD_W:0]   dx, dy;
  logic [S_W-1:0]            s_val;
  logic [S_W-1:0]            mul_a;
  logic [MAG_W-1:0]          mul_b;
  logic [PROD_W-1:0]         prod;
  logic [RAD_W-1:0]          trial;
  logic [R_W-1:0]            root;
  logic signed [OUT_W-1:0]   offy, off_cur;
  logic signed [OUT_W:0]     farx_sum, fary_sum;
  logic signed [OUT_W-1:0]   farx, fary;

  assign s_val = {cfg_i.stretch, {FRAC_W{1'b0}}};
  assign dx    = (sel_q ? {cmd_q.bx[COORD_W-1], cmd_q.bx} : {cmd_q.ax[COORD_W-1], cmd_q.ax})
               - {cfg_i.light_x[COORD_W-1], cfg_i.light_x};
  assign dy    = (sel_q ? {cmd_q.by[COORD_W-1], cmd_q.by} : {cmd_q.ay[COORD_W-1], cmd_q.ay})
               - {cfg_i.light_y[COORD_W-1], cfg_i.light_y};

  // shared multiplier: squares, then stretch times magnitude
  always_comb begin
    case (state_q)
      ST_SQX: begin
        mul_a = {{(S_W-MAG_W){1'b0}}, adx_q};
        mul_b = adx_q;
      end
      ST_SQY: begin
        mul_a = {{(S_W-MAG_W){1'b0}}, ady_q};
        mul_b = ady_q;
      end
      default: begin
        mul_a = s_val;
        mul_b = axis_q ? ady_q : adx_q;
      end
    endcase
  end
  assign prod  = mul_a * mul_b;
  assign trial = root_q + bit_q;
  assign root  = root_q[R_W-1:0];

  assign off_cur  = (axis_q ? negy_q : negx_q)
                  ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign offy     = (root == '0) ? '0 : off_cur;
  assign farx_sum = {{(OUT_W+1-COORD_W){px_q[COORD_W-1]}}, px_q}
                  + {offx_q[OUT_W-1], offx_q};
  assign fary_sum = {{(OUT_W+1-COORD_W){py_q[COORD_W-1]}}, py_q}
                  + {offy[OUT_W-1], offy};
  assign farx     = sat_out(farx_sum);
  assign fary     = sat_out(fary_sum);

  assign pop_o       = (state_q == ST_IDLE) && cmd_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        cmd_q <= cmd_i;
      end
      ST_DIFF: begin
        px_q   <= sel_q ? cmd_q.bx : cmd_q.ax;
        py_q   <= sel_q ? cmd_q.by : cmd_q.ay;
        negx_q <= dx[COORD_W];
        negy_q <= dy[COORD_W];
        adx_q  <= dx[COORD_W] ? MAG_W'(-dx) : dx[MAG_W-1:0];
        ady_q  <= dy[COORD_W] ? MAG_W'(-dy) : dy[MAG_W-1:0];
      end
      ST_SQX: begin
        acc_q <= prod;
      end
      ST_SQY: begin
        rad_q  <= {acc_q + prod, 16'd0};
        root_q <= '0;
        bit_q  <= RAD_W'(1) << 48;
      end
      ST_SQRT: begin
        if (rad_q >= trial) begin
          rad_q  <= rad_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      ST_MUL: begin
        rem_q  <= {{(NUM_W-PROD_W-9){1'b0}}, prod, 9'd0} + {{(NUM_W-R_W){1'b0}}, root};
        den_q  <= {{(NUM_W-R_W-1-(Q_W-1)){1'b0}}, root, 1'b0, {(Q_W-1){1'b0}}};
        quo_q  <= '0;
        dcnt_q <= 5'(Q_W - 1);
      end
      ST_DIV: begin
        if (rem_q >= den_q) begin
          rem_q <= rem_q - den_q;
          quo_q <= {quo_q[Q_W-2:0], 1'b1};
        end else begin
          quo_q <= {quo_q[Q_W-2:0], 1'b0};
        end
        den_q  <= den_q >> 1;
        dcnt_q <= dcnt_q - 5'd1;
      end
      ST_STORE: begin
        if (sel_q) begin
          fbx_q <= farx;
          fby_q <= fary;
        end else begin
          fax_q <= farx;
          fay_q <= fary;
        end
      end
      default: begin
      end
    endcase
    // hold the finished x quotient before the y division starts
    if (state_q == ST_MUL) begin
      if (root == '0) begin
        offx_q <= '0;
      end else if (axis_q) begin
        offx_q <= negx_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
      end
    end
    if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
      out_q.near_a_x  <= OUT_W'(cmd_q.ax);
      out_q.near_a_y  <= OUT_W'(cmd_q.ay);
      out_q.near_b_x  <= OUT_W'(cmd_q.bx);
      out_q.near_b_y  <= OUT_W'(cmd_q.by);
      out_q.far_a_x   <= fax_q;
      out_q.far_a_y   <= fay_q;
      out_q.far_b_x   <= fbx_q;
      out_q.far_b_y   <= fby_q;
      out_q.last_quad <= cmd_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= 1'b0;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          sel_q <= 1'b0;
          if (cmd_valid_i) begin
            state_q <= ST_DIFF;
          end
        end
        ST_DIFF:  state_q <= ST_SQX;
        ST_SQX:   state_q <= ST_SQY;
        ST_SQY:   state_q <= ST_SQRT;
        ST_SQRT: begin
          axis_q <= 1'b0;
          if (bit_q[0]) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          // zero length: leave the point where it is
          state_q <= (root == '0) ? ST_STORE : ST_DIV;
        end
        ST_DIV: begin
          if (dcnt_q == 5'd0) begin
            if (axis_q) begin
              state_q <= ST_STORE;
            end else begin
              axis_q  <= 1'b1;
              state_q <= ST_MUL;
            end
          end
        end
        ST_STORE: begin
          sel_q   <= 1'b1;
          state_q <= sel_q ? ST_OUT : ST_DIFF;
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/shadow_quad_extruder.sv =====
// ----------------------------------------------------------------------------
// shadow_quad_extruder
// 2-D shadow quad generator for one point light, fed one vertex per request.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | in_item_i  (vertex, close flag)
//  out     | output    | out_valid/out_ready| out_item_o (quad corners, last)
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index_i, cfg_data_i
//
// For each quad the back end does, per end point, one
// difference, two squares, a 25-step square root and two 19-step divisions,
// all through one shared multiplier, one root unit and one divider.
// A vertex gives up to two quads; a two-entry queue lets the front take new
// vertices while the back works. Reset restores the register defaults and
// closes any open polygon. Either side may stall.
// ----------------------------------------------------------------------------
module shadow_quad_extruder (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  sqe_pkg::in_item_t                     in_item_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output sqe_pkg::out_item_t                    out_item_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [sqe_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [sqe_pkg::CFG_DAT_W-1:0]         cfg_data_i
);
  import sqe_pkg::*;

  cfg_t      cfg_q;
  logic      push, full, pop, cmd_valid;
  quad_cmd_t cmd_w, cmd_r;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.light_on <= 1'b1;
      cfg_q.light_x  <= '0;
      cfg_q.light_y  <= '0;
      cfg_q.stretch  <= STRETCH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LIGHT_ON: cfg_q.light_on <= cfg_data_i[0];
        REG_LIGHT_X:  cfg_q.light_x  <= cfg_data_i[COORD_W-1:0];
        REG_LIGHT_Y:  cfg_q.light_y  <= cfg_data_i[COORD_W-1:0];
        REG_STRETCH:  cfg_q.stretch  <= cfg_data_i[STRETCH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sqe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .light_on_i (cfg_q.light_on),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .cmd_o      (cmd_w),
    .full_i     (full)
  );

  sqe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_w),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .rdata_o (cmd_r)
  );

  sqe_extrude u_extrude (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_r),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
